// ===== hdl/pid_tilt_speed_controller_macros.svh =====
// Assertion macros shared by the tilt speed controller RTL.
`ifndef PID_TILT_SPEED_CONTROLLER_MACROS_SVH
`define PID_TILT_SPEED_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pts_pkg.sv =====
// Package: constants, register codes and shared types of the tilt speed controller.
package pts_pkg;

    localparam int FRAC_BITS        = 8;
    localparam int SAMPLE_PERIOD_MS = 40;
    localparam int DIV_SHIFT        = 24;
    localparam int DIV_RECIP        = (1 << DIV_SHIFT) / SAMPLE_PERIOD_MS;

    localparam int ANGLE_W = 17;
    localparam int GAIN_W  = 16;
    localparam int ILIM_W  = 8;
    localparam int SLIM_W  = 10;
    localparam int SPEED_W = 11;
    localparam int ERR_W   = 18;
    localparam int DIFF_W  = 19;
    localparam int MAG_W   = 18;
    localparam int OPA_W   = 19;
    localparam int OPB_W   = 26;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int SHR_W   = 27;
    localparam int ACC_W   = 32;
    localparam int CIDX_W  = 3;

    localparam int ILIM_RESET = 100;
    localparam int SLIM_RESET = 400;

    typedef enum logic [CIDX_W-1:0] {
        REG_REFERENCE_ANGLE = 3'd0,
        REG_GAIN_P          = 3'd1,
        REG_GAIN_I          = 3'd2,
        REG_GAIN_D          = 3'd3,
        REG_INTEGRAL_LIMIT  = 3'd4,
        REG_SPEED_LIMIT     = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_KI_ERR,
        MUL_KP_ERR,
        MUL_KD_DERIV,
        MUL_MAG_RECIP,
        MUL_INTEG_PERIOD,
        MUL_Q_PERIOD
    } mul_sel_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] ref_angle;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [ILIM_W-1:0]         integ_limit;
        logic [SLIM_W-1:0]         speed_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] deriv;
        logic [MAG_W-1:0]         mag;
        logic [MAG_W-1:0]         quot;
        logic signed [ERR_W-1:0]  integ;
    } mul_ops_t;

endpackage

// ===== hdl/pid_tilt_speed_controller.sv =====
// Top level: PID tilt-to-speed controller, sequencer around one shared multiplier.
// Sequencer: 10 steps, ST_ERR through ST_OUT, from input transfer to result valid;
// ST_OUT waits for a free output. One sample is processed at a time (shared multiplier).
// A new sample may be taken while the previous result still waits for transfer.
// Reset: rst_n asynchronous, active low; clears integral, previous error,
// sequencer and output valid; registers return to their reset values.
`include "pid_tilt_speed_controller_macros.svh"

module pid_tilt_speed_controller
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [16:0] angle
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [10:0] speed
    output logic [0:0]                  m_tuser,   // [0] saturated
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pts_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [pts_pkg::ANGLE_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MI,
        ST_MP,
        ST_MQ,
        ST_MINT,
        ST_MQD,
        ST_FIX,
        ST_MD,
        ST_SUM,
        ST_OUT
    } state_t;

    pts_pkg::cfg_t     cfg;
    pts_pkg::mul_sel_t mul_sel;
    pts_pkg::mul_ops_t mul_ops;

    logic signed [pts_pkg::PROD_W-1:0]  prod;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic signed [pts_pkg::ERR_W-1:0]   integ_reg;
    logic signed [pts_pkg::ERR_W-1:0]   prev_reg;
    logic [pts_pkg::SPEED_W-1:0]        speed_reg;
    logic                               sat_reg;

    logic signed [pts_pkg::ANGLE_W-1:0] angle_reg;
    logic signed [pts_pkg::ERR_W-1:0]   err_reg;
    logic signed [pts_pkg::DIFF_W-1:0]  diff_reg;
    logic [pts_pkg::MAG_W-1:0]          quot_reg;
    logic signed [pts_pkg::DIFF_W-1:0]  deriv_reg;
    logic signed [pts_pkg::ACC_W-1:0]   acc_reg;

    logic signed [pts_pkg::ERR_W-1:0]   err_now;
    logic signed [pts_pkg::DIFF_W-1:0]  diff_now;
    logic signed [pts_pkg::DIFF_W-1:0]  diff_abs;
    logic [pts_pkg::MAG_W-1:0]          mag;
    logic signed [pts_pkg::PROD_W-1:0]  prod_sh;
    logic signed [pts_pkg::SHR_W-1:0]   prod_shr;
    logic signed [pts_pkg::SHR_W:0]     integ_sum;
    logic signed [pts_pkg::SHR_W:0]     ilim_pos;
    logic signed [pts_pkg::SHR_W:0]     ilim_neg;
    logic signed [pts_pkg::ERR_W-1:0]   integ_next;
    logic [pts_pkg::MAG_W+1:0]          rem;
    logic [pts_pkg::MAG_W-1:0]          quot_fix;
    logic signed [pts_pkg::DIFF_W-1:0]  deriv_next;
    logic signed [pts_pkg::ACC_W-1:0]   acc_abs;
    logic [pts_pkg::ACC_W-1:0]          acc_rnd;
    logic [pts_pkg::ACC_W-pts_pkg::FRAC_BITS-1:0] rnd_mag;
    logic                               sat_next;
    logic [pts_pkg::SLIM_W-1:0]         out_mag;
    logic [pts_pkg::SPEED_W-1:0]        speed_next;
    logic [pts_pkg::SPEED_W-1:0]        speed_abs;
    logic                               out_free;

    pts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pts_mult u_mult
    (
        .clk  (clk),
        .sel  (mul_sel),
        .ops  (mul_ops),
        .cfg  (cfg),
        .prod (prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, speed_reg};
    assign m_tuser  = sat_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign err_now  = pts_pkg::ERR_W'(cfg.ref_angle) - pts_pkg::ERR_W'(angle_reg);
    assign diff_now = pts_pkg::DIFF_W'(err_now) - pts_pkg::DIFF_W'(prev_reg);
    assign diff_abs = diff_reg[pts_pkg::DIFF_W-1] ? -diff_reg : diff_reg;
    assign mag      = diff_abs[pts_pkg::MAG_W-1:0];

    assign mul_ops.err   = err_reg;
    assign mul_ops.deriv = deriv_reg;
    assign mul_ops.mag   = mag;
    assign mul_ops.quot  = quot_reg;
    assign mul_ops.integ = integ_reg;

    always_comb
    begin
        case (state_reg)
            ST_MI:   mul_sel = pts_pkg::MUL_KI_ERR;
            ST_MP:   mul_sel = pts_pkg::MUL_KP_ERR;
            ST_MQ:   mul_sel = pts_pkg::MUL_MAG_RECIP;
            ST_MINT: mul_sel = pts_pkg::MUL_INTEG_PERIOD;
            ST_MQD:  mul_sel = pts_pkg::MUL_Q_PERIOD;
            ST_MD:   mul_sel = pts_pkg::MUL_KD_DERIV;
            default: mul_sel = pts_pkg::MUL_KI_ERR;
        endcase
    end

    // gain products floored by the fraction shift
    assign prod_sh  = prod >>> pts_pkg::FRAC_BITS;
    assign prod_shr = prod_sh[pts_pkg::SHR_W-1:0];

    // integral update with clamp to +/- limit
    assign integ_sum = (pts_pkg::SHR_W+1)'(integ_reg) + (pts_pkg::SHR_W+1)'(prod_shr);
    assign ilim_pos  = $signed((pts_pkg::SHR_W+1)'({cfg.integ_limit,
                                                    {pts_pkg::FRAC_BITS{1'b0}}}));
    assign ilim_neg  = -ilim_pos;

    always_comb
    begin
        if (integ_sum > ilim_pos)
            integ_next = ilim_pos[pts_pkg::ERR_W-1:0];
        else if (integ_sum < ilim_neg)
            integ_next = ilim_neg[pts_pkg::ERR_W-1:0];
        else
            integ_next = integ_sum[pts_pkg::ERR_W-1:0];
    end

    // reciprocal quotient may fall one short: one compare and correct
    assign rem        = (pts_pkg::MAG_W+2)'(mag) - prod[pts_pkg::MAG_W+1:0];
    assign quot_fix   = (rem >= (pts_pkg::MAG_W+2)'(pts_pkg::SAMPLE_PERIOD_MS))
                        ? quot_reg + 1'b1 : quot_reg;
    assign deriv_next = diff_reg[pts_pkg::DIFF_W-1] ? -$signed({1'b0, quot_fix})
                                                    : $signed({1'b0, quot_fix});

    // round half away from zero, then saturate
    assign acc_abs    = acc_reg[pts_pkg::ACC_W-1] ? -acc_reg : acc_reg;
    assign acc_rnd    = acc_abs + pts_pkg::ACC_W'(1 << (pts_pkg::FRAC_BITS - 1));
    assign rnd_mag    = acc_rnd[pts_pkg::ACC_W-1:pts_pkg::FRAC_BITS];
    assign sat_next   = rnd_mag > (pts_pkg::ACC_W-pts_pkg::FRAC_BITS)'(cfg.speed_limit);
    assign out_mag    = sat_next ? cfg.speed_limit : rnd_mag[pts_pkg::SLIM_W-1:0];
    assign speed_next = acc_reg[pts_pkg::ACC_W-1] ? -{1'b0, out_mag} : {1'b0, out_mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            integ_reg    <= '0;
            prev_reg     <= '0;
            speed_reg    <= '0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_tvalid)
                        state_reg <= ST_ERR;
                ST_ERR:
                begin
                    prev_reg  <= err_now;
                    state_reg <= ST_MI;
                end
                ST_MI:   state_reg <= ST_MP;
                ST_MP:
                begin
                    integ_reg <= integ_next;
                    state_reg <= ST_MQ;
                end
                ST_MQ:   state_reg <= ST_MINT;
                ST_MINT: state_reg <= ST_MQD;
                ST_MQD:  state_reg <= ST_FIX;
                ST_FIX:  state_reg <= ST_MD;
                ST_MD:   state_reg <= ST_SUM;
                ST_SUM:  state_reg <= ST_OUT;
                ST_OUT:
                    if (out_free)
                    begin
                        speed_reg    <= speed_next;
                        sat_reg      <= sat_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            angle_reg <= $signed(s_tdata[pts_pkg::ANGLE_W-1:0]);
        if (state_reg == ST_ERR)
        begin
            err_reg  <= err_now;
            diff_reg <= diff_now;
        end
        if (state_reg == ST_MQ)
            acc_reg <= pts_pkg::ACC_W'(prod_shr);
        if (state_reg == ST_MINT)
            quot_reg <= prod[pts_pkg::DIV_SHIFT +: pts_pkg::MAG_W];
        if (state_reg == ST_MQD)
            acc_reg <= acc_reg + $signed(prod[pts_pkg::ACC_W-1:0]);
        if (state_reg == ST_FIX)
            deriv_reg <= deriv_next;
        if (state_reg == ST_SUM)
            acc_reg <= acc_reg + pts_pkg::ACC_W'(prod_shr);
    end

    assign speed_abs = speed_reg[pts_pkg::SPEED_W-1] ? -speed_reg : speed_reg;

    `PTS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `PTS_ASSERT_SAME(a_sat_at_limit, m_tvalid && m_tuser[0], speed_abs == {1'b0, cfg.speed_limit}, "saturated result not at limit")
    `PTS_ASSERT_SAME(a_result_from_seq, $rose(m_tvalid), $past(state_reg) == ST_OUT, "result raised outside output step")

endmodule

// ===== hdl/pts_cfg.sv =====
// Configuration register file of the tilt speed controller.
module pts_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pts_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [pts_pkg::ANGLE_W-1:0] cfg_data,
    output pts_pkg::cfg_t               cfg
);

    pts_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_angle   <= '0;
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.integ_limit <= pts_pkg::ILIM_W'(pts_pkg::ILIM_RESET);
            cfg_reg.speed_limit <= pts_pkg::SLIM_W'(pts_pkg::SLIM_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pts_pkg::REG_REFERENCE_ANGLE:
                    cfg_reg.ref_angle <= $signed(cfg_data);
                pts_pkg::REG_GAIN_P:
                    cfg_reg.gain_p <= $signed(cfg_data[pts_pkg::GAIN_W-1:0]);
                pts_pkg::REG_GAIN_I:
                    cfg_reg.gain_i <= $signed(cfg_data[pts_pkg::GAIN_W-1:0]);
                pts_pkg::REG_GAIN_D:
                    cfg_reg.gain_d <= $signed(cfg_data[pts_pkg::GAIN_W-1:0]);
                pts_pkg::REG_INTEGRAL_LIMIT:
                    cfg_reg.integ_limit <= cfg_data[pts_pkg::ILIM_W-1:0];
                pts_pkg::REG_SPEED_LIMIT:
                    cfg_reg.speed_limit <= cfg_data[pts_pkg::SLIM_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

// ===== hdl/pts_mult.sv =====
// Shared signed multiplier with operand select and registered product.
module pts_mult
(
    input  logic                               clk,
    input  pts_pkg::mul_sel_t                  sel,
    input  pts_pkg::mul_ops_t                  ops,
    input  pts_pkg::cfg_t                      cfg,
    output logic signed [pts_pkg::PROD_W-1:0]  prod
);

    logic signed [pts_pkg::OPA_W-1:0]  op_a;
    logic signed [pts_pkg::OPB_W-1:0]  op_b;
    logic signed [pts_pkg::PROD_W-1:0] prod_next;
    logic signed [pts_pkg::PROD_W-1:0] prod_reg;

    always_comb
    begin
        case (sel)
            pts_pkg::MUL_KI_ERR:
            begin
                op_a = pts_pkg::OPA_W'(ops.err);
                op_b = pts_pkg::OPB_W'(cfg.gain_i);
            end
            pts_pkg::MUL_KP_ERR:
            begin
                op_a = pts_pkg::OPA_W'(ops.err);
                op_b = pts_pkg::OPB_W'(cfg.gain_p);
            end
            pts_pkg::MUL_KD_DERIV:
            begin
                op_a = ops.deriv;
                op_b = pts_pkg::OPB_W'(cfg.gain_d);
            end
            pts_pkg::MUL_MAG_RECIP:
            begin
                op_a = $signed({1'b0, ops.mag});
                op_b = pts_pkg::OPB_W'(pts_pkg::DIV_RECIP);
            end
            pts_pkg::MUL_INTEG_PERIOD:
            begin
                op_a = pts_pkg::OPA_W'(ops.integ);
                op_b = pts_pkg::OPB_W'(pts_pkg::SAMPLE_PERIOD_MS);
            end
            pts_pkg::MUL_Q_PERIOD:
            begin
                op_a = $signed({1'b0, ops.quot});
                op_b = pts_pkg::OPB_W'(pts_pkg::SAMPLE_PERIOD_MS);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the PID tilt speed controller: directed and random samples against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEM_TARGET   = 1750;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 200;
    localparam int ANGLE_MAX     = 46080;
    localparam int TDATA_W       = 24;

    localparam logic [pts_pkg::CIDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [pts_pkg::CIDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct {
        logic [pts_pkg::SPEED_W-1:0] speed;
        logic                        saturated;
    } speed_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [TDATA_W-1:0]            s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [15:0]                   m_tdata;
    logic [0:0]                    m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pts_pkg::CIDX_W-1:0]    cfg_index;
    logic [pts_pkg::ANGLE_W-1:0]   cfg_data;

    pts_pkg::cfg_t   tuning;
    longint          integ_acc;
    longint          last_err;
    speed_result_t   pending_speeds[$];
    int              fail_count   = 0;
    int              sent_count   = 0;
    int              walk_pos     = 0;
    bit              in_gaps_on   = 1'b1;
    bit              out_gaps_on  = 1'b1;
    bit              hold_request = 1'b0;

    pid_tilt_speed_controller uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic reset_tuning();
        tuning.ref_angle   = '0;
        tuning.gain_p      = '0;
        tuning.gain_i      = '0;
        tuning.gain_d      = '0;
        tuning.integ_limit = pts_pkg::ILIM_W'(pts_pkg::ILIM_RESET);
        tuning.speed_limit = pts_pkg::SLIM_W'(pts_pkg::SLIM_RESET);
        integ_acc = 0;
        last_err  = 0;
    endtask

    // floor shifts on products, clamp, truncating derivative, round half away from zero
    task automatic predict_speed(input logic [pts_pkg::ANGLE_W-1:0] angle_bits);
        longint        ang;
        longint        err;
        longint        ilim;
        longint        integ;
        longint        deriv;
        longint        total;
        longint        rounded;
        longint        slim;
        longint        half;
        speed_result_t res;
        ang   = $signed(angle_bits);
        err   = longint'($signed(tuning.ref_angle)) - ang;
        ilim  = longint'(tuning.integ_limit) <<< pts_pkg::FRAC_BITS;
        integ = integ_acc
              + ((longint'($signed(tuning.gain_i)) * err) >>> pts_pkg::FRAC_BITS);
        if (integ > ilim)
            integ = ilim;
        if (integ < -ilim)
            integ = -ilim;
        integ_acc = integ;
        deriv    = (err - last_err) / longint'(pts_pkg::SAMPLE_PERIOD_MS);
        last_err = err;
        total = ((longint'($signed(tuning.gain_p)) * err) >>> pts_pkg::FRAC_BITS)
              + ((longint'($signed(tuning.gain_d)) * deriv) >>> pts_pkg::FRAC_BITS)
              + integ * longint'(pts_pkg::SAMPLE_PERIOD_MS);
        half = longint'(1) <<< (pts_pkg::FRAC_BITS - 1);
        if (total >= 0)
            rounded = (total + half) >>> pts_pkg::FRAC_BITS;
        else
            rounded = -((-total + half) >>> pts_pkg::FRAC_BITS);
        slim = longint'(tuning.speed_limit);
        res.saturated = 1'b0;
        if (rounded > slim)
        begin
            rounded = slim;
            res.saturated = 1'b1;
        end
        else if (rounded < -slim)
        begin
            rounded = -slim;
            res.saturated = 1'b1;
        end
        res.speed = rounded[pts_pkg::SPEED_W-1:0];
        pending_speeds.push_back(res);
    endtask

    always @(posedge clk)
    begin : result_check
        speed_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_speeds.size() == 0)
            begin
                $error("unexpected speed transfer: speed %0d",
                       $signed(m_tdata[pts_pkg::SPEED_W-1:0]));
                fail_count++;
            end
            else
            begin
                want = pending_speeds.pop_front();
                if (m_tdata[pts_pkg::SPEED_W-1:0] !== want.speed)
                begin
                    $error("speed: expected %0d, got %0d",
                           $signed(want.speed), $signed(m_tdata[pts_pkg::SPEED_W-1:0]));
                    fail_count++;
                end
                if (m_tuser[0] !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : sink_pacing
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else if (out_gaps_on && $urandom_range(0, 4) == 0)
            begin
                gap_left = pick_gap();
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [pts_pkg::CIDX_W-1:0] idx,
                             input logic [pts_pkg::ANGLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            pts_pkg::REG_REFERENCE_ANGLE: tuning.ref_angle   = value;
            pts_pkg::REG_GAIN_P:          tuning.gain_p      = value[pts_pkg::GAIN_W-1:0];
            pts_pkg::REG_GAIN_I:          tuning.gain_i      = value[pts_pkg::GAIN_W-1:0];
            pts_pkg::REG_GAIN_D:          tuning.gain_d      = value[pts_pkg::GAIN_W-1:0];
            pts_pkg::REG_INTEGRAL_LIMIT:  tuning.integ_limit = value[pts_pkg::ILIM_W-1:0];
            pts_pkg::REG_SPEED_LIMIT:     tuning.speed_limit = value[pts_pkg::SLIM_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // unused upper bits of the write data are sometimes filled with noise
    function automatic logic [pts_pkg::ANGLE_W-1:0] with_junk(
        input logic [pts_pkg::ANGLE_W-1:0] value,
        input int width);
        logic [pts_pkg::ANGLE_W-1:0] keep;
        keep = pts_pkg::ANGLE_W'((1 << width) - 1);
        if ($urandom_range(0, 2) == 0)
            return (value & keep) | (pts_pkg::ANGLE_W'($urandom) & ~keep);
        return value & keep;
    endfunction

    task automatic set_regs(input int ref_v, input int kp, input int ki, input int kd,
                            input int ilim, input int slim);
        write_reg(pts_pkg::REG_REFERENCE_ANGLE,
                  with_junk(ref_v[pts_pkg::ANGLE_W-1:0], pts_pkg::ANGLE_W));
        write_reg(pts_pkg::REG_GAIN_P,
                  with_junk(kp[pts_pkg::ANGLE_W-1:0], pts_pkg::GAIN_W));
        write_reg(pts_pkg::REG_GAIN_I,
                  with_junk(ki[pts_pkg::ANGLE_W-1:0], pts_pkg::GAIN_W));
        write_reg(pts_pkg::REG_GAIN_D,
                  with_junk(kd[pts_pkg::ANGLE_W-1:0], pts_pkg::GAIN_W));
        write_reg(pts_pkg::REG_INTEGRAL_LIMIT,
                  with_junk(ilim[pts_pkg::ANGLE_W-1:0], pts_pkg::ILIM_W));
        write_reg(pts_pkg::REG_SPEED_LIMIT,
                  with_junk(slim[pts_pkg::ANGLE_W-1:0], pts_pkg::SLIM_W));
    endtask

    task automatic send_angle(input int value);
        logic [pts_pkg::ANGLE_W-1:0] bits;
        int                          gap;
        bits = value[pts_pkg::ANGLE_W-1:0];
        gap  = in_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - pts_pkg::ANGLE_W){1'b0}}, bits};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_speed(bits);
        sent_count++;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_speeds.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_speeds.size() != 0)
        begin
            $error("%0d speed results never arrived", pending_speeds.size());
            fail_count++;
            pending_speeds.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int rand_gain(input int span);
        case (span)
            0: return int'($urandom_range(0, 1023)) - 512;
            1: return int'($urandom_range(0, 65535)) - 32768;
            default:
                case ($urandom_range(0, 3))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return 0;
                    default: return 256;
                endcase
        endcase
    endfunction

    function automatic int rand_ref();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
        if (r < 16)
            return ANGLE_MAX;
        if (r < 17)
            return -ANGLE_MAX;
        return $urandom_range(0, 131071);
    endfunction

    function automatic int rand_limit(input int top);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return top;
        return $urandom_range(0, top);
    endfunction

    // mostly a slow drift around the set point, sometimes wild samples
    function automatic int next_angle(input int mode);
        if (mode < 12)
        begin
            walk_pos += int'($urandom_range(0, 600)) - 300;
            if (walk_pos > ANGLE_MAX)
                walk_pos = ANGLE_MAX;
            if (walk_pos < -ANGLE_MAX)
                walk_pos = -ANGLE_MAX;
            return walk_pos;
        end
        if (mode < 17)
            return int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
        return $urandom_range(0, 131071);
    endfunction

    task automatic test_reset_defaults();
        send_angle(ANGLE_MAX);
        send_angle(-ANGLE_MAX);
        send_angle(0);
        drain();
    endtask

    task automatic test_proportional_rounding();
        set_regs(0, 256, 0, 0, 100, 1023);
        send_angle(-256);
        send_angle(128);
        send_angle(-128);
        send_angle(127);
        drain();
    endtask

    task automatic test_saturation();
        set_regs(0, 32767, 0, 0, 100, 1023);
        send_angle(-ANGLE_MAX);
        send_angle(ANGLE_MAX);
        send_angle(32'h10000);
        send_angle(32'h0FFFF);
        drain();
        set_regs(0, 32767, 0, 0, 100, 0);
        send_angle(0);
        send_angle(1000);
        drain();
    endtask

    task automatic test_integral_clamp();
        set_regs(ANGLE_MAX, 0, 32767, 0, 1, 1023);
        send_angle(-ANGLE_MAX);
        send_angle(-ANGLE_MAX);
        send_angle(-ANGLE_MAX);
        drain();
        // zero limit pins the integral
        set_regs(ANGLE_MAX, 0, -32768, 0, 0, 1023);
        send_angle(0);
        drain();
        set_regs(-ANGLE_MAX, 0, -32768, 0, 255, 1023);
        send_angle(ANGLE_MAX);
        send_angle(ANGLE_MAX);
        drain();
    endtask

    task automatic test_derivative();
        set_regs(0, 0, 0, 32767, 100, 1023);
        send_angle(0);
        send_angle(-ANGLE_MAX);
        send_angle(ANGLE_MAX);
        send_angle(ANGLE_MAX - 39);
        drain();
    endtask

    task automatic test_spare_index();
        write_reg(IDX_SPARE_LO, '1);
        write_reg(IDX_SPARE_HI, '1);
        send_angle(-256);
        drain();
    endtask

    task automatic test_backpressure();
        set_regs(0, 512, 64, 1024, 100, 400);
        in_gaps_on   = 1'b0;
        out_gaps_on  = 1'b0;
        hold_request = 1'b1;
        walk_pos     = 0;
        repeat (24) send_angle(next_angle(0));
        drain();
    endtask

    task automatic run_random_phase();
        int items;
        int span;
        int angle_mode;
        int ref_v;
        int r;
        r = $urandom_range(0, 9);
        span = (r < 5) ? 0 : (r < 8) ? 1 : 2;
        in_gaps_on  = ($urandom_range(0, 3) != 0);
        out_gaps_on = ($urandom_range(0, 3) != 0);
        ref_v = rand_ref();
        set_regs(ref_v, rand_gain(span), rand_gain(span), rand_gain(span),
                 rand_limit(255), rand_limit(1023));
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                      pts_pkg::ANGLE_W'($urandom));
        walk_pos   = ref_v;
        angle_mode = $urandom_range(0, 19);
        items      = $urandom_range(20, 80);
        repeat (items) send_angle(next_angle(angle_mode));
        drain();
    endtask

    task automatic test_random_traffic();
        int target;
        target = sent_count + ITEM_TARGET;
        while (sent_count < target)
            run_random_phase();
    endtask

    initial
    begin : test_sequence
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        reset_tuning();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_proportional_rounding();
        test_saturation();
        test_integral_clamp();
        test_derivative();
        test_spare_index();
        test_backpressure();
        test_random_traffic();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== pid_tilt_speed_controller.f =====
+incdir+hdl
hdl/pts_pkg.sv
hdl/pts_cfg.sv
hdl/pts_mult.sv
hdl/pid_tilt_speed_controller.sv
bench/tb_top.sv
